// ===== rtl/rskc_pkg.sv =====
// ----------------------------------------------------------------------------
// rskc_pkg
// Shared types, constants and helper functions of the RMS soft knee compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package rskc_pkg;

  localparam int DELAY_DEPTH_DEF   = 32;
  localparam int RMS_AVG_COEFF_DEF = 655;

  // shared arithmetic units
  localparam int MUL_W = 32;
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;

  // configuration port
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_RATIO     = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_RELEASE   = 3'd3;
  localparam logic [2:0] REG_KNEE      = 3'd4;
  localparam logic [2:0] REG_MAKEUP    = 3'd5;

  localparam logic [15:0] THRESHOLD_RST = 16'hEC00;
  localparam logic [9:0]  RATIO_RST     = 10'd64;
  localparam logic [15:0] ATTACK_RST    = 16'd655;
  localparam logic [15:0] RELEASE_RST   = 16'd66;
  localparam logic [12:0] KNEE_RST      = 13'd0;
  localparam logic [13:0] MAKEUP_RST    = 14'd0;

  localparam logic [15:0] LEVEL_FLOOR = 16'hA000;   // -96 dB in Q7.8
  localparam logic [23:0] GAIN_MAX    = 24'hFFFFFF;
  localparam logic [23:0] GAIN_UNITY  = 24'h010000;
  localparam logic [17:0] LOG_SCALE   = 18'd197284;  // 10*log10(2) in Q16
  localparam logic [17:0] EXP_SCALE   = 18'd174166;  // log2(10)/20 in Q20
  localparam logic [33:0] EXP_BIAS    = 34'd2882863104;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PWR_OLD,
    ST_PWR_SQ,
    ST_PWR_NEW,
    ST_NORM,
    ST_LOG_SQ,
    ST_LOG_DB,
    ST_SLOPE,
    ST_KNEE_MUL,
    ST_KNEE_DIV,
    ST_GAIN,
    ST_EXP_MUL,
    ST_EXP_STEP,
    ST_EXP_FIN,
    ST_TARGET,
    ST_SMOOTH_OLD,
    ST_SMOOTH_NEW,
    ST_OUT_MUL,
    ST_OUT
  } seq_state_t;

  // 2^(2^-(k+1)) in Q16
  function automatic logic [16:0] exp2_step(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0: v = 17'd92682;
      4'd1: v = 17'd77936;
      4'd2: v = 17'd71468;
      4'd3: v = 17'd68438;
      4'd4: v = 17'd66971;
      4'd5: v = 17'd66250;
      4'd6: v = 17'd65892;
      4'd7: v = 17'd65714;
      4'd8: v = 17'd65625;
      4'd9: v = 17'd65580;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // applies the integer part of the exponent, rounding on right shifts
  function automatic logic [23:0] lin_shift(input logic [17:0] r,
                                            input logic signed [6:0] e);
    logic [25:0] up;
    logic [5:0]  s;
    logic [33:0] half;
    logic [33:0] dn;
    logic [23:0] res;
    up = '0;
    s = '0;
    half = '0;
    dn = '0;
    res = GAIN_MAX;
    if (!e[6]) begin
      if (e[5:3] == 3'd0) begin
        up = {8'd0, r} << e[2:0];
        res = (up > {2'b00, GAIN_MAX}) ? GAIN_MAX : up[23:0];
      end
    end else begin
      s = 6'(-e);
      half = 34'd1 << (s - 6'd1);
      dn = ({16'd0, r} + half) >> s;
      res = (dn > {10'd0, GAIN_MAX}) ? GAIN_MAX : dn[23:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rms_soft_knee_compressor.sv =====
// ----------------------------------------------------------------------------
// rms_soft_knee_compressor
// Feedforward RMS compressor with soft knee, makeup gain and lookahead delay.
// ----------------------------------------------------------------------------
// work per item: up to 44 products on the shared bit-serial multiplier, plus the
//   shared divider
// throughput: one item at a time; the next item is taken once the result
//   sits in the output register
// reset: registers to their defaults, power 0, gain unity, delay line reads 0
`default_nettype none

module rms_soft_knee_compressor import rskc_pkg::*; #(
  parameter int DELAY_DEPTH   = DELAY_DEPTH_DEF,
  parameter int RMS_AVG_COEFF = RMS_AVG_COEFF_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // audio_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // audio_out
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  seq_state_t state, state_next;

  // configuration
  logic [15:0] thr_r;
  logic [9:0]  ratio_r;
  logic [15:0] att_r;
  logic [15:0] rel_r;
  logic [12:0] knee_r;
  logic [13:0] mkup_r;
  logic        cfg_wr;

  // datapath
  logic [15:0]        x_r;
  logic [31:0]        pe;
  logic [23:0]        sg;
  logic [63:0]        acc;
  logic [31:0]        nm;
  logic [4:0]         ncnt;
  logic [4:0]         lexp;
  logic [11:0]        lbits;
  logic [3:0]         li;
  logic signed [15:0] lvl;
  logic [16:0]        slope;
  logic signed [19:0] thr2;
  logic signed [19:0] dbg;
  logic               exp_sel;
  logic signed [6:0]  ey;
  logic [9:0]         efb;
  logic [17:0]        er;
  logic [3:0]         ek;
  logic [23:0]        newg;
  logic [23:0]        mkg;
  logic [23:0]        target;
  logic [AW-1:0]      pos;
  logic               line_full;

  // shared units
  logic             mul_req, mul_start;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_prod;
  unit_stat_t       mul_stat;
  logic             div_req, div_start;
  logic [31:0]      div_n;
  logic [15:0]      div_d;
  logic [31:0]      div_q;
  unit_stat_t       div_stat;

  logic [15:0] rd_data;
  logic        out_free;
  logic        ram_we;

  // combinational helpers
  logic [15:0]        abs_x;
  logic [63:0]        p_sum;
  logic [31:0]        p_new;
  logic signed [17:0] lval;
  logic [16:0]        abs_l;
  logic [63:0]        lmag;
  logic [9:0]         r_eff;
  logic [15:0]        t_cl;
  logic signed [19:0] t2, d2, k20, neg_t2, den, diff, neg_diff;
  logic               in_knee;
  logic [63:0]        gq;
  logic [15:0]        dbg_cl, din16, u16;
  logic [33:0]        ey_y;
  logic               ebit;
  logic [63:0]        rr;
  logic [63:0]        tsum;
  logic [23:0]        tsat;
  logic [15:0]        coef;
  logic [16:0]        om;
  logic [63:0]        gsum;
  logic [23:0]        gsat;
  logic [31:0]        sq;
  logic [15:0]        delayed;
  logic signed [41:0] o_tot;
  logic signed [25:0] o_q;
  logic [15:0]        o_sat;

  rskc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .stat (mul_stat)
  );

  rskc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_n),
    .den  (div_d),
    .quot (div_q),
    .stat (div_stat)
  );

  rskc_ram #(
    .WIDTH(16),
    .DEPTH(DELAY_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos),
    .wdata(x_r),
    .re   (s_tvalid && s_tready),
    .raddr(pos),
    .rdata(rd_data)
  );

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_r <= THRESHOLD_RST;
      ratio_r <= RATIO_RST;
      att_r <= ATTACK_RST;
      rel_r <= RELEASE_RST;
      knee_r <= KNEE_RST;
      mkup_r <= MAKEUP_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_THRESHOLD: thr_r <= pwdata[15:0];
        REG_RATIO:     ratio_r <= pwdata[9:0];
        REG_ATTACK:    att_r <= pwdata[15:0];
        REG_RELEASE:   rel_r <= pwdata[15:0];
        REG_KNEE:      knee_r <= pwdata[12:0];
        REG_MAKEUP:    mkup_r <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_THRESHOLD: prdata = {16'd0, thr_r};
      REG_RATIO:     prdata = {22'd0, ratio_r};
      REG_ATTACK:    prdata = {16'd0, att_r};
      REG_RELEASE:   prdata = {16'd0, rel_r};
      REG_KNEE:      prdata = {19'd0, knee_r};
      REG_MAKEUP:    prdata = {18'd0, mkup_r};
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------- arithmetic around the shared units ----------------
  assign abs_x = x_r[15] ? 16'(-x_r) : x_r;
  assign p_sum = acc + mul_prod + 64'd32768;
  assign p_new = p_sum[47:16];
  assign sq = mul_prod[61:30];

  assign lval = $signed({1'b0, lexp, lbits}) - 18'sd122880;
  assign abs_l = lval[17] ? 17'(-lval) : lval[16:0];
  assign lmag = mul_prod + 64'd524288;

  assign r_eff = (ratio_r < 10'd16) ? 10'd16 : ratio_r;

  // knee math in Q7.9
  assign t_cl = thr_r[15] ? thr_r : 16'd0;
  assign t2 = {{3{t_cl[15]}}, t_cl, 1'b0};
  assign d2 = {{3{lvl[15]}}, lvl, 1'b0};
  assign k20 = {7'd0, knee_r};
  assign neg_t2 = -t2;
  assign den = k20 + ((neg_t2 < k20) ? neg_t2 : k20);
  assign in_knee = (knee_r != 13'd0) && (d2 > t2 - k20) && (d2 < t2 + k20);
  assign diff = thr2 - d2;
  assign neg_diff = -diff;
  assign gq = (mul_prod + 64'd65536) >> 17;

  // dB to linear
  assign dbg_cl = (dbg < -20'sd32768) ? 16'h8000 : dbg[15:0];
  assign din16 = exp_sel ? {{2{mkup_r[13]}}, mkup_r} : dbg_cl;
  assign u16 = {~din16[15], din16[14:0]};
  assign ey_y = mul_prod[33:0] + EXP_BIAS;
  assign ebit = efb[4'd9 - ek];
  assign rr = mul_prod + 64'd32768;

  assign tsum = mul_prod + 64'd32768;
  assign tsat = (tsum[63:40] != 24'd0) ? GAIN_MAX : tsum[39:16];

  // attack when the new gain drops below the smoothed one
  assign coef = (newg < sg) ? att_r : rel_r;
  assign om = 17'd65536 - {1'b0, coef};
  assign gsum = acc + mul_prod + 64'd32768;
  assign gsat = (gsum[63:40] != 24'd0) ? GAIN_MAX : gsum[39:16];

  assign delayed = line_full ? rd_data : 16'd0;
  assign o_tot = $signed({2'b00, mul_prod[39:0]}) - $signed({3'b000, sg, 15'd0})
               + 42'sd32768;
  assign o_q = o_tot[41:16];
  always_comb begin
    if (o_q > 26'sd32767) begin
      o_sat = 16'h7FFF;
    end else if (o_q < -26'sd32768) begin
      o_sat = 16'h8000;
    end else begin
      o_sat = o_q[15:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign ram_we = (state == ST_OUT) && out_free;
  assign s_tready = (state == ST_IDLE);

  assign mul_start = mul_req && !mul_stat.busy && !mul_stat.done;
  assign div_start = div_req && !div_stat.busy && !div_stat.done;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_req = 1'b0;
    mul_a = 32'd0;
    mul_b = 32'd0;
    div_req = 1'b0;
    div_n = 32'd0;
    div_d = 16'd0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_PWR_OLD;
        end
      end
      ST_PWR_OLD: begin
        mul_req = 1'b1;
        mul_a = pe;
        mul_b = 32'(65536 - RMS_AVG_COEFF);
        if (mul_stat.done) begin
          state_next = ST_PWR_SQ;
        end
      end
      ST_PWR_SQ: begin
        mul_req = 1'b1;
        mul_a = {16'd0, abs_x};
        mul_b = {16'd0, abs_x};
        if (mul_stat.done) begin
          state_next = ST_PWR_NEW;
        end
      end
      ST_PWR_NEW: begin
        mul_req = 1'b1;
        mul_a = nm;
        mul_b = 32'(RMS_AVG_COEFF);
        if (mul_stat.done) begin
          state_next = (p_new == 32'd0) ? ST_SLOPE : ST_NORM;
        end
      end
      ST_NORM: begin
        if (nm[31]) begin
          state_next = ST_LOG_SQ;
        end
      end
      ST_LOG_SQ: begin
        mul_req = 1'b1;
        mul_a = nm;
        mul_b = nm;
        if (mul_stat.done && li == 4'd0) begin
          state_next = ST_LOG_DB;
        end
      end
      ST_LOG_DB: begin
        mul_req = 1'b1;
        mul_a = {15'd0, abs_l};
        mul_b = {14'd0, LOG_SCALE};
        if (mul_stat.done) begin
          state_next = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        div_req = 1'b1;
        div_n = 32'd1048576 + {23'd0, r_eff[9:1]};
        div_d = {6'd0, r_eff};
        if (div_stat.done) begin
          state_next = in_knee ? ST_KNEE_MUL : ST_GAIN;
        end
      end
      ST_KNEE_MUL: begin
        mul_req = 1'b1;
        mul_a = {15'd0, slope};
        mul_b = {19'd0, knee_r};
        if (mul_stat.done) begin
          state_next = ST_KNEE_DIV;
        end
      end
      ST_KNEE_DIV: begin
        div_req = 1'b1;
        div_n = acc[31:0] + {17'd0, den[15:1]};
        div_d = den[15:0];
        if (div_stat.done) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin
        mul_req = diff[19];
        mul_a = {15'd0, slope};
        mul_b = {12'd0, neg_diff};
        if (!diff[19] || mul_stat.done) begin
          state_next = ST_EXP_MUL;
        end
      end
      ST_EXP_MUL: begin
        mul_req = 1'b1;
        mul_a = {16'd0, u16};
        mul_b = {14'd0, EXP_SCALE};
        if (mul_stat.done) begin
          state_next = ST_EXP_STEP;
        end
      end
      ST_EXP_STEP: begin
        mul_req = ebit;
        mul_a = {14'd0, er};
        mul_b = {15'd0, exp2_step(ek)};
        if ((!ebit || mul_stat.done) && ek == 4'd9) begin
          state_next = ST_EXP_FIN;
        end
      end
      ST_EXP_FIN: begin
        state_next = exp_sel ? ST_TARGET : ST_EXP_MUL;
      end
      ST_TARGET: begin
        mul_req = 1'b1;
        mul_a = {8'd0, newg};
        mul_b = {8'd0, mkg};
        if (mul_stat.done) begin
          state_next = ST_SMOOTH_OLD;
        end
      end
      ST_SMOOTH_OLD: begin
        mul_req = 1'b1;
        mul_a = {15'd0, om};
        mul_b = {8'd0, sg};
        if (mul_stat.done) begin
          state_next = ST_SMOOTH_NEW;
        end
      end
      ST_SMOOTH_NEW: begin
        mul_req = 1'b1;
        mul_a = {16'd0, coef};
        mul_b = {8'd0, target};
        if (mul_stat.done) begin
          state_next = ST_OUT_MUL;
        end
      end
      ST_OUT_MUL: begin
        mul_req = 1'b1;
        mul_a = {8'd0, sg};
        mul_b = {16'd0, delayed ^ 16'h8000};
        if (mul_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- state registers of the model ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pe <= 32'd0;
      sg <= GAIN_UNITY;
      pos <= '0;
      line_full <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_PWR_NEW && mul_stat.done) begin
        pe <= p_new;
      end
      if (state == ST_SMOOTH_NEW && mul_stat.done) begin
        sg <= gsat;
      end
      if (ram_we) begin
        m_tvalid <= 1'b1;
        if (pos == AW'(DELAY_DEPTH - 1)) begin
          pos <= '0;
          line_full <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          x_r <= s_tdata;
        end
      end
      ST_PWR_OLD: begin
        if (mul_stat.done) begin
          acc <= mul_prod;
        end
      end
      ST_PWR_SQ: begin
        if (mul_stat.done) begin
          nm <= mul_prod[31:0];
        end
      end
      ST_PWR_NEW: begin
        if (mul_stat.done) begin
          nm <= p_new;
          ncnt <= 5'd0;
          lbits <= 12'd0;
          li <= 4'd11;
          lvl <= LEVEL_FLOOR;
        end
      end
      ST_NORM: begin
        if (nm[31]) begin
          nm <= {1'b0, nm[31:1]};
          lexp <= 5'd31 - ncnt;
        end else begin
          nm <= {nm[30:0], 1'b0};
          ncnt <= ncnt + 1'b1;
        end
      end
      ST_LOG_SQ: begin
        if (mul_stat.done) begin
          if (sq[31]) begin
            nm <= {1'b0, sq[31:1]};
            lbits[li] <= 1'b1;
          end else begin
            nm <= sq;
          end
          li <= li - 1'b1;
        end
      end
      ST_LOG_DB: begin
        if (mul_stat.done) begin
          lvl <= lval[17] ? 16'(-lmag[35:20]) : lmag[35:20];
        end
      end
      ST_SLOPE: begin
        if (div_stat.done) begin
          slope <= 17'd65536 - div_q[16:0];
          thr2 <= in_knee ? (t2 - k20) : t2;
        end
      end
      ST_KNEE_MUL: begin
        if (mul_stat.done) begin
          acc <= mul_prod;
        end
      end
      ST_KNEE_DIV: begin
        if (div_stat.done) begin
          slope <= div_q[16:0];
        end
      end
      ST_GAIN: begin
        exp_sel <= 1'b0;
        if (!diff[19]) begin
          dbg <= 20'sd0;
        end else if (mul_stat.done) begin
          dbg <= -$signed({2'b00, gq[17:0]});
        end
      end
      ST_EXP_MUL: begin
        if (mul_stat.done) begin
          ey <= $signed({1'b0, ey_y[33:28]}) - 7'sd32;
          efb <= ey_y[27:18];
          er <= 18'd65536;
          ek <= 4'd0;
        end
      end
      ST_EXP_STEP: begin
        if (!ebit) begin
          ek <= ek + 1'b1;
        end else if (mul_stat.done) begin
          er <= rr[33:16];
          ek <= ek + 1'b1;
        end
      end
      ST_EXP_FIN: begin
        if (exp_sel) begin
          mkg <= lin_shift(er, ey);
        end else begin
          newg <= lin_shift(er, ey);
          exp_sel <= 1'b1;
        end
      end
      ST_TARGET: begin
        if (mul_stat.done) begin
          target <= tsat;
        end
      end
      ST_SMOOTH_OLD: begin
        if (mul_stat.done) begin
          acc <= mul_prod;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= o_sat;
        end
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy && !div_stat.busy)
    else $error("multiplier started while a unit is busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mul_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while idle");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while the previous one is in work");

endmodule

`default_nettype wire

// ===== rtl/rskc_ram.sv =====
// ----------------------------------------------------------------------------
// rskc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rskc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rskc_mul.sv =====
// ----------------------------------------------------------------------------
// rskc_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rskc_mul import rskc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] prod,
  output unit_stat_t         stat
);

  localparam int CW = $clog2(MUL_W);

  logic [MUL_W-1:0]   mcand;
  logic [2*MUL_W-1:0] acc;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               done;
  logic [MUL_W:0]     sum;

  // multiplier sits in the low half and shifts out as the product shifts in
  assign sum = {1'b0, acc[2*MUL_W-1:MUL_W]} + (acc[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc <= {{MUL_W{1'b0}}, b};
    end else if (busy) begin
      acc <= {sum, acc[MUL_W-1:1]};
    end
  end

  assign prod = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== rtl/rskc_div.sv =====
// ----------------------------------------------------------------------------
// rskc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rskc_div import rskc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic [DIV_N_W-1:0] quot,
  output unit_stat_t         stat
);

  localparam int CW = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] den_r;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_N_W-1:0] q;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               done;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem, q[DIV_N_W-1]};
  assign ge = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem <= '0;
      q <= num;
    end else if (busy) begin
      rem <= ge ? DIV_D_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_D_W-1:0];
      q <= {q[DIV_N_W-2:0], ge};
    end
  end

  assign quot = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RMS soft knee compressor. Audio samples stream
// in, and every output sample is compared with a bit-exact fixed-point model
// of the power detector, the static curve, gain smoothing and lookahead line.
// The settings are rewritten between phases through the register port.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rskc_pkg::*;

  localparam int        LINE_LEN   = 32;
  localparam int        AVG_COEFF  = 655;
  localparam longint    CYCLE_CAP  = 10_000_000;
  localparam int        HOLD_LEN   = 3000;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;     // audio_in
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;          // audio_out
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  rms_soft_knee_compressor u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // ---- model state ----
  logic [15:0] thr_reg;
  logic [9:0]  ratio_reg;
  logic [15:0] attack_reg, release_reg;
  logic [12:0] knee_reg;
  logic [13:0] makeup_reg;
  logic [31:0] power_acc;
  logic [23:0] gain_acc;
  logic [15:0] line_mem [LINE_LEN];
  int          line_idx;

  longint exp_steps [10] = '{92682, 77936, 71468, 68438, 66971,
                             66250, 65892, 65714, 65625, 65580};

  logic [15:0] pending_out [$];
  int          errors = 0;
  longint      cycles = 0;
  bit          hold_rx = 1'b0;
  bit          tx_gappy = 1'b1;
  bit          rx_gappy = 1'b1;

  function automatic int power_to_db(input logic [31:0] p);
    int              e;
    longint unsigned m;
    longint          l;
    if (p == 0) return -24576;
    e = 31;
    while (!p[e]) e--;
    m = (e <= 30) ? (longint'(p) << (30 - e)) : (longint'(p) >> (e - 30));
    l = longint'(e) * 4096;
    for (int i = 11; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        l += longint'(1) << i;
      end
    end
    l -= 30 * 4096;
    if (l >= 0) return int'((l * 197284 + (1 << 19)) >> 20);
    return -int'(((-l) * 197284 + (1 << 19)) >> 20);
  endfunction

  function automatic logic [23:0] db_to_gain(input int d_in);
    int     d;
    longint y;
    int     e;
    int     fb;
    longint r;
    d = d_in;
    if (d < -32768) d = -32768;
    if (d > 32767) d = 32767;
    y = longint'(d) * 174166 + (longint'(32) << 28);
    e = int'(y >>> 28) - 32;
    fb = int'((y & 64'hFFF_FFFF) >> 18);
    r = 65536;
    for (int k = 0; k < 10; k++)
      if (fb[9-k]) r = (r * exp_steps[k] + 32768) >> 16;
    if (e >= 0) begin
      if (e >= 8) return GAIN_MAX;
      r = r << e;
    end else begin
      if (-e >= 40) return '0;
      r = (r + (longint'(1) << (-e - 1))) >> (-e);
    end
    return (r > longint'(GAIN_MAX)) ? GAIN_MAX : r[23:0];
  endfunction

  function automatic logic [15:0] compress_sample(input logic [15:0] smp);
    longint x, p, slope, rr, den, mag, target, g, c, prod;
    int     lvl, t, k, t2, d2, thr2, diff, dbg;
    logic [23:0] newg, mk;
    x = longint'($signed(smp));
    p = (longint'(power_acc) * (65536 - AVG_COEFF) + x * x * AVG_COEFF + 32768) >> 16;
    power_acc = p[31:0];
    lvl = power_to_db(power_acc);

    t = int'($signed(thr_reg));
    if (t > 0) t = 0;
    rr = (ratio_reg < 16) ? 16 : longint'(ratio_reg);
    slope = 65536 - (1048576 + rr / 2) / rr;

    k = int'(knee_reg);
    t2 = 2 * t;
    d2 = 2 * lvl;
    thr2 = t2;
    if (k > 0 && d2 > t2 - k && d2 < t2 + k) begin
      den = k + (((-t2) < k) ? -t2 : k);
      slope = (slope * k + den / 2) / den;
      thr2 = t2 - k;
    end
    diff = thr2 - d2;
    dbg = 0;
    if (diff < 0) begin
      mag = slope * longint'(-diff);
      dbg = -int'((mag + 65536) >> 17);
    end

    newg = db_to_gain(dbg);
    mk = db_to_gain(int'($signed(makeup_reg)));
    target = (longint'(newg) * mk + 32768) >> 16;
    if (target > longint'(GAIN_MAX)) target = GAIN_MAX;
    // attack while the raw curve gain is below the running gain
    c = (newg < gain_acc) ? longint'(attack_reg) : longint'(release_reg);
    g = ((65536 - c) * gain_acc + c * target + 32768) >> 16;
    if (g > longint'(GAIN_MAX)) g = GAIN_MAX;
    gain_acc = g[23:0];

    prod = (g * longint'($signed(line_mem[line_idx])) + 32768) >>> 16;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    line_mem[line_idx] = smp;
    line_idx = (line_idx + 1) % LINE_LEN;
    return prod[15:0];
  endfunction

  task automatic model_reset();
    thr_reg = THRESHOLD_RST;
    ratio_reg = RATIO_RST;
    attack_reg = ATTACK_RST;
    release_reg = RELEASE_RST;
    knee_reg = KNEE_RST;
    makeup_reg = MAKEUP_RST;
    power_acc = '0;
    gain_acc = GAIN_UNITY;
    foreach (line_mem[i]) line_mem[i] = '0;
    line_idx = 0;
  endtask

  // register write; junk in the upper bits checks the width masking
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] word;
    case (idx)
      REG_THRESHOLD: mask = 32'hFFFF;
      REG_RATIO:     mask = 32'h3FF;
      REG_ATTACK:    mask = 32'hFFFF;
      REG_RELEASE:   mask = 32'hFFFF;
      REG_KNEE:      mask = 32'h1FFF;
      REG_MAKEUP:    mask = 32'h3FFF;
      default:       mask = 32'h0;
    endcase
    word = ($urandom & ~mask) | (val & mask);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THRESHOLD: thr_reg = word[15:0];
      REG_RATIO:     ratio_reg = word[9:0];
      REG_ATTACK:    attack_reg = word[15:0];
      REG_RELEASE:   release_reg = word[15:0];
      REG_KNEE:      knee_reg = word[12:0];
      REG_MAKEUP:    makeup_reg = word[13:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_curve(input int thr, input int ratio, input int att, input int rel,
                           input int knee, input int mk);
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_RATIO, ratio);
    reg_write(REG_ATTACK, att);
    reg_write(REG_RELEASE, rel);
    reg_write(REG_KNEE, knee);
    reg_write(REG_MAKEUP, mk);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic [15:0] smp, input bit known,
                             input logic [15:0] known_out);
    int          gap;
    logic [15:0] predicted;
    gap = tx_gappy ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = smp;
    do @(posedge clk); while (!s_tready);
    predicted = compress_sample(smp);
    pending_out.push_back(known ? known_out : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  task automatic random_run(input int n);
    int          kind;
    logic [15:0] smp;
    kind = 0;
    for (int i = 0; i < n; i++) begin
      // sustained level blocks so the slow power detector settles
      if (i % 40 == 0) kind = $urandom_range(0, 4);
      case (kind)
        0: smp = $urandom;
        1: smp = $urandom_range(0, 1) ? 16'($urandom_range(16384, 32767))
                                      : 16'(-$urandom_range(16384, 32768));
        2: smp = 16'($signed($urandom_range(0, 128)) - 64);
        3: smp = '0;
        default: smp = $urandom_range(0, 1) ? 16'($urandom_range(2000, 9000))
                                            : 16'(-$urandom_range(2000, 9000));
      endcase
      send_sample(smp, 1'b0, '0);
    end
  endtask

  typedef struct {
    logic [15:0] smp;
    bit          known;
    logic [15:0] out;
  } stim_row_t;

  // the delay line reads zero for the first samples after reset
  stim_row_t opening [20] = '{
    '{16'h0000, 1'b1, 16'h0000}, '{16'h7FFF, 1'b1, 16'h0000},
    '{16'h8000, 1'b1, 16'h0000}, '{16'h0001, 1'b1, 16'h0000},
    '{16'hFFFF, 1'b1, 16'h0000}, '{16'h5555, 1'b1, 16'h0000},
    '{16'hAAAA, 1'b1, 16'h0000}, '{16'h7FFF, 1'b1, 16'h0000},
    '{16'h8000, 1'b1, 16'h0000}, '{16'h7FFF, 1'b1, 16'h0000},
    '{16'h8000, 1'b1, 16'h0000}, '{16'h4000, 1'b1, 16'h0000},
    '{16'hC000, 1'b1, 16'h0000}, '{16'h0000, 1'b1, 16'h0000},
    '{16'h0100, 1'b1, 16'h0000}, '{16'hFF00, 1'b1, 16'h0000},
    '{16'h7FFF, 1'b1, 16'h0000}, '{16'h8001, 1'b1, 16'h0000},
    '{16'h1234, 1'b1, 16'h0000}, '{16'hEDCB, 1'b1, 16'h0000}
  };

  // sink side
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        m_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_rx = 1'b0;
      end
      n = rx_gappy ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected output sample %h", $realtime, m_tdata);
        errors++;
      end else begin
        logic [15:0] want;
        want = pending_out.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: audio_out expected %h actual %h", $realtime, want, m_tdata);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening[i]) send_sample(opening[i].smp, opening[i].known, opening[i].out);
    random_run(110);
    drain();

    // spare addresses must not disturb anything
    reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_B, 32'h0000_1234);
    set_curve(0, 512, 65535, 65535, 6144, 6144);
    rx_gappy = 1'b0;
    random_run(120);
    drain();

    // unity ratio and frozen gain
    set_curve(-24576, 16, 0, 0, 0, -6144);
    tx_gappy = 1'b0;
    rx_gappy = 1'b1;
    random_run(110);
    drain();

    // ratio below one (clamped to unity), long sink stall while samples keep coming
    set_curve(-2560, 0, 30000, 2000, 6144, 0);
    hold_rx = 1'b1;
    random_run(120);
    drain();

    tx_gappy = 1'b1;
    set_curve(-6000, 1023, 8000, 500, 3000, 8191);
    random_run(110);
    drain();

    // positive threshold, widest knee, most negative makeup
    set_curve(32767, 100, 655, 66, 8191, -8192);
    random_run(110);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_gappy = $urandom_range(0, 2) != 0;
      rx_gappy = $urandom_range(0, 2) != 0;
      set_curve(-$urandom_range(0, 24576), $urandom_range(16, 512), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 6144),
                $signed($urandom_range(0, 12288)) - 6144);
      random_run(115);
      drain();
    end

    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rskc_pkg.sv
rtl/rskc_ram.sv
rtl/rskc_mul.sv
rtl/rskc_div.sv
rtl/rms_soft_knee_compressor.sv
test/tb.sv
